FILE: src/matrix_multiply_4x4_assert.svh
// Assertion macros for the 4x4 matrix multiplier.
// Each macro expands to a clocked concurrent assertion on clk, disabled while arst_n is low.
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MM4_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// When cond holds, expr must hold at the next clock edge.
`define MM4_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);
`else
`define MM4_ASSERT_ALWAYS(label, expr, msg)
`define MM4_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

FILE: src/mm4_pkg.sv
// Shared constants and types for the 4x4 matrix multiplier.
// No dependencies; imported by the interfaces, the controller, the datapath, the top level and the testbench.
package mm4_pkg;
	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int CELLS     = DIM * DIM;
	localparam int IDX_W     = 4;
	localparam int K_W       = $clog2(DIM);
	localparam int VAL_W     = 32;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int ACC_W     = PROD_W + $clog2(DIM);

	localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic SEL_LEFT  = 1'b0;
	localparam logic SEL_RIGHT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_en;
		logic             issue;
		logic             first;
		logic             last_k;
		logic [IDX_W-1:0] a_addr;
		logic [IDX_W-1:0] b_addr;
		logic [IDX_W-1:0] out_idx;
		logic             out_last;
	} mm4_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic out_free;
		logic result_loaded;
	} mm4_status_t;
endpackage

FILE: src/mm4_if.sv
// Handshake channel interfaces for element loads and product words.
// Depends on mm4_pkg for the field widths.
interface mm4_in_if;
	import mm4_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    matrix_sel;
	logic [IDX_W-1:0]        elem_index;
	logic signed [VAL_W-1:0] elem_value;
	logic                    compute;

	modport source (output valid, matrix_sel, elem_index, elem_value, compute, input ready);
	modport sink (input valid, matrix_sel, elem_index, elem_value, compute, output ready);
endinterface

interface mm4_out_if;
	import mm4_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        out_index;
	logic signed [VAL_W-1:0] out_value;
	logic                    last;

	modport source (output valid, out_index, out_value, last, input ready);
	modport sink (input valid, out_index, out_value, last, output ready);
endinterface

FILE: src/mm4_datapath.sv
// Operand stores, multiply-accumulate pipeline, saturation and output register.
// Depends on mm4_pkg; driven by mm4_ctrl through mm4_cmd_t.
module mm4_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mm4_pkg::mm4_cmd_t             cmd,
	input  logic                          wr_sel,
	input  logic [mm4_pkg::IDX_W-1:0]     wr_index,
	input  logic [mm4_pkg::VAL_W-1:0]     wr_value,
	output mm4_pkg::mm4_status_t          status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mm4_pkg::IDX_W-1:0]     out_index,
	output logic [mm4_pkg::VAL_W-1:0]     out_value,
	output logic                          out_last
);
	import mm4_pkg::*;

	logic [VAL_W-1:0]        left_mem [CELLS];
	logic [VAL_W-1:0]        right_mem [CELLS];

	logic [VAL_W-1:0]        a_s1, b_s1;
	logic                    valid_s1, first_s1, last_k_s1;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic                    olast_s1, olast_s2, olast_s3;
	logic signed [PROD_W-1:0] p_s2;
	logic                    valid_s2, first_s2, last_k_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic                    done_s3;
	logic signed [ACC_W-1:0] p_ext, shifted;
	logic                    fits;
	logic [VAL_W-1:0]        sat_val;
	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_index_q;
	logic [VAL_W-1:0]        out_value_q;
	logic                    out_last_q;

	// Stores and the registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_sel == SEL_LEFT) begin
			left_mem[wr_index] <= wr_value;
		end
		if (cmd.wr_en && wr_sel == SEL_RIGHT) begin
			right_mem[wr_index] <= wr_value;
		end
		a_s1 <= left_mem[cmd.a_addr];
		b_s1 <= right_mem[cmd.b_addr];
	end

	// Payload of the pipeline stages.
	always_ff @(posedge clk) begin
		idx_s1   <= cmd.out_idx;
		olast_s1 <= cmd.out_last;
		p_s2     <= $signed(a_s1) * $signed(b_s1);
		idx_s2   <= idx_s1;
		olast_s2 <= olast_s1;
		if (valid_s2) begin
			acc_q  <= first_s2 ? p_ext : acc_q + p_ext;
			idx_s3 <= idx_s2;
			olast_s3 <= olast_s2;
		end
	end

	assign p_ext = {{(ACC_W-PROD_W){p_s2[PROD_W-1]}}, p_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			first_s1  <= 1'b0;
			last_k_s1 <= 1'b0;
			valid_s2  <= 1'b0;
			first_s2  <= 1'b0;
			last_k_s2 <= 1'b0;
			done_s3   <= 1'b0;
		end else begin
			valid_s1  <= cmd.issue;
			first_s1  <= cmd.first;
			last_k_s1 <= cmd.last_k;
			valid_s2  <= valid_s1;
			first_s2  <= first_s1;
			last_k_s2 <= last_k_s1;
			done_s3   <= valid_s2 && last_k_s2;
		end
	end

	// Arithmetic shift rounds toward minus infinity; the sum fits when all bits
	// above the result's sign bit agree with it.
	assign shifted = acc_q >>> FRAC_BITS;
	assign fits    = (&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]);
	assign sat_val = fits ? shifted[VAL_W-1:0] : (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX);

	always_ff @(posedge clk) begin
		if (done_s3) begin
			out_index_q <= idx_s3;
			out_value_q <= sat_val;
			out_last_q  <= olast_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s3) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free      = !out_valid_q;
	assign status.result_loaded = done_s3;

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
endmodule

FILE: src/mm4_ctrl.sv
// Controller: accepts element loads and sequences the row, column and
// inner-product counters for each product word. Depends on mm4_pkg.
module mm4_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_compute,
	output logic                 in_ready,
	input  mm4_pkg::mm4_status_t status,
	output mm4_pkg::mm4_cmd_t    cmd
);
	import mm4_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HOLD,
		S_ISSUE,
		S_WAIT
	} state_t;

	state_t         state_q;
	logic [K_W-1:0] row_q, col_q, k_q;
	logic           k_end, row_end, col_end;

	assign k_end   = k_q == K_W'(DIM - 1);
	assign row_end = row_q == K_W'(DIM - 1);
	assign col_end = col_q == K_W'(DIM - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					k_q   <= '0;
					if (in_valid && in_compute) begin
						state_q <= S_HOLD;
					end
				end
				// Start a word only once the output register is empty.
				S_HOLD: begin
					if (status.out_free) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (k_end) begin
						k_q     <= '0;
						state_q <= S_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (status.result_loaded) begin
						if (row_end && col_end) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_HOLD;
							row_q   <= row_end ? '0 : row_q + 1'b1;
							col_q   <= row_end ? col_q + 1'b1 : col_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready     = state_q == S_IDLE;
	assign cmd.wr_en    = in_valid && in_ready;
	assign cmd.issue    = state_q == S_ISSUE;
	assign cmd.first    = k_q == '0;
	assign cmd.last_k   = k_end;
	assign cmd.a_addr   = IDX_W'(int'(k_q) * DIM + int'(row_q));
	assign cmd.b_addr   = IDX_W'(int'(col_q) * DIM + int'(k_q));
	assign cmd.out_idx  = IDX_W'(int'(col_q) * DIM + int'(row_q));
	assign cmd.out_last = row_end && col_end;
endmodule

FILE: src/matrix_multiply_4x4.sv
// 4x4 signed Q16.16 matrix multiplier, R = A * B, all matrices column-major.
// Each accepted word stores one element of A or B. A word with compute set
// stores its element and then produces the sixteen elements of R in
// column-major order, the last one marked. Each product word takes four reads
// of each store's single read port (one per inner-product term through one
// 32x32 multiplier), then drains the multiply-accumulate pipeline. The
// controller starts a word only once the output register is empty, so the
// product words never overlap. No element loads are taken until the last
// product word has been loaded into the output register. Sums are exact,
// shifted right with rounding toward minus infinity and saturated to 32
// bits. Stores are not cleared at reset.
// Depends on mm4_pkg, mm4_if, mm4_ctrl, mm4_datapath and the assertion header.
`include "matrix_multiply_4x4_assert.svh"
module matrix_multiply_4x4 (
	input  logic     clk,
	input  logic     arst_n,
	mm4_in_if.sink   elem,
	mm4_out_if.source result
);
	import mm4_pkg::*;

	mm4_cmd_t    cmd;
	mm4_status_t status;

	mm4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (elem.valid),
		.in_compute (elem.compute),
		.in_ready   (elem.ready),
		.status     (status),
		.cmd        (cmd)
	);

	mm4_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_sel    (elem.matrix_sel),
		.wr_index  (elem.elem_index),
		.wr_value  (elem.elem_value),
		.status    (status),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_index (result.out_index),
		.out_value (result.out_value),
		.out_last  (result.last)
	);

	// A finished word must never land on a word still waiting at the output.
	`MM4_ASSERT_ALWAYS(a_no_overwrite, !(status.result_loaded && result.valid), "output word overwritten")
	// Reads for a product never overlap an element store.
	`MM4_ASSERT_ALWAYS(a_no_issue_on_load, !(cmd.issue && cmd.wr_en), "read issued during store")
	// Product reads start only once the output register has emptied.
	`MM4_ASSERT_ALWAYS(a_no_issue_while_full, !(cmd.issue && result.valid), "read issued while full")
	// A loaded word shows up as valid at the output on the next cycle.
	`MM4_ASSERT_NEXT(a_load_visible, status.result_loaded, result.valid, "loaded word not presented")
endmodule

FILE: verif/matrix_multiply_4x4_tb.sv
// Self-checking testbench for matrix_multiply_4x4: loads elements of A and B, requests
// products and checks every product word against its own fixed-point predictor.
// Depends on mm4_pkg, mm4_if and the matrix_multiply_4x4 RTL.
module matrix_multiply_4x4_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mm4_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 11;
	localparam int RANDOM_WORDS    = 170;
	localparam int HOLD_OFF_AFTER  = 240;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 40;
	localparam int IDLE_LIMIT      = 4000;
	localparam int NUM_DIRECTED    = 17;

	localparam logic [VAL_W-1:0] Q_ONE     = 32'h0001_0000;
	localparam logic [VAL_W-1:0] Q_THREE   = 32'h0003_0000;
	localparam logic [VAL_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
	localparam logic [VAL_W-1:0] MINUS_LSB = '1;
	localparam logic [VAL_W-1:0] PLUS_LSB  = 32'h0000_0001;
	localparam logic signed [ACC_W-1:0] ACC_MAX =
		{{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN =
		{{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic             sel;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             compute;
		logic             typed;
		logic [VAL_W-1:0] r0;
	} load_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             last;
	} product_word_t;

	logic clk = 1'b0;
	logic arst_n;

	mm4_in_if  loads ();
	mm4_out_if products ();

	matrix_multiply_4x4 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (loads),
		.result (products)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Shadow copies of both operand stores and the product words still owed.
	logic [VAL_W-1:0] left_shadow [CELLS];
	logic [VAL_W-1:0] right_shadow [CELLS];
	product_word_t    expected_products [$];
	int               mismatches = 0;
	int               results_seen = 0;
	int               idle_cycles = 0;
	int               burst_left = 0;

	// With A holding the identity and B zero, the element at index 0 of the product
	// reduces to A[0]*B[0] plus the row-0/column-0 terms, so it can be typed in.
	load_word_t directed_rows [NUM_DIRECTED] = '{
		'{SEL_RIGHT, 4'd0,  SAT_MAX,    1'b1, 1'b1, SAT_MAX},
		'{SEL_RIGHT, 4'd0,  SAT_MIN,    1'b1, 1'b1, SAT_MIN},
		'{SEL_LEFT,  4'd0,  SAT_MAX,    1'b0, 1'b0, '0},
		'{SEL_RIGHT, 4'd0,  SAT_MAX,    1'b1, 1'b1, SAT_MAX},
		'{SEL_RIGHT, 4'd0,  SAT_MIN,    1'b1, 1'b1, SAT_MIN},
		'{SEL_LEFT,  4'd0,  SAT_MIN,    1'b0, 1'b0, '0},
		'{SEL_RIGHT, 4'd0,  SAT_MIN,    1'b1, 1'b1, SAT_MAX},
		'{SEL_LEFT,  4'd0,  MINUS_LSB,  1'b0, 1'b0, '0},
		'{SEL_RIGHT, 4'd0,  PLUS_LSB,   1'b1, 1'b1, MINUS_LSB},
		'{SEL_LEFT,  4'd0,  PLUS_LSB,   1'b0, 1'b0, '0},
		'{SEL_RIGHT, 4'd0,  PLUS_LSB,   1'b1, 1'b1, '0},
		'{SEL_LEFT,  4'd0,  Q_ONE,      1'b0, 1'b0, '0},
		'{SEL_RIGHT, 4'd0,  Q_THREE,    1'b1, 1'b1, Q_THREE},
		'{SEL_LEFT,  4'd15, Q_NEG_ONE,  1'b0, 1'b0, '0},
		'{SEL_RIGHT, 4'd15, 32'h1234_5678, 1'b1, 1'b0, '0},
		'{SEL_LEFT,  4'd4,  SAT_MAX,    1'b0, 1'b0, '0},
		'{SEL_RIGHT, 4'd1,  SAT_MAX,    1'b1, 1'b1, SAT_MAX}
	};

	// Update the shadow stores and, on a compute word, queue all sixteen product words.
	task automatic take_word(input load_word_t w);
		logic signed [ACC_W-1:0] sum;
		logic signed [ACC_W-1:0] scaled;
		product_word_t p;
		if (w.sel == SEL_RIGHT) begin
			right_shadow[w.index] = w.value;
		end else begin
			left_shadow[w.index] = w.value;
		end
		if (w.compute) begin
			for (int col = 0; col < DIM; col++) begin
				for (int row = 0; row < DIM; row++) begin
					sum = '0;
					for (int k = 0; k < DIM; k++) begin
						sum += $signed(left_shadow[k*DIM+row]) *
							$signed(right_shadow[col*DIM+k]);
					end
					// Arithmetic shift rounds toward minus infinity.
					scaled = sum >>> FRAC_BITS;
					p.index = IDX_W'(col*DIM + row);
					if (scaled > ACC_MAX) begin
						p.value = SAT_MAX;
					end else if (scaled < ACC_MIN) begin
						p.value = SAT_MIN;
					end else begin
						p.value = scaled[VAL_W-1:0];
					end
					p.last = (col*DIM + row == CELLS-1);
					if (w.typed && col == 0 && row == 0) begin
						p.value = w.r0;
					end
					expected_products.push_back(p);
				end
			end
		end
	endtask

	// Offer one word in bursts with random gaps between them; return once it is taken.
	task automatic send_word(input load_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				loads.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		loads.valid      <= 1'b1;
		loads.matrix_sel <= w.sel;
		loads.elem_index <= w.index;
		loads.elem_value <= w.value;
		loads.compute    <= w.compute;
		do @(posedge clk); while (!loads.ready);
		take_word(w);
	endtask

	function automatic load_word_t random_load(input logic sel, input logic [IDX_W-1:0] index,
			input logic compute);
		load_word_t w;
		w = '0;
		w.sel = sel;
		w.index = index;
		w.compute = compute;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: w.value = $urandom();
			4, 5, 6: w.value = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
			7, 8: w.value = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
			default: begin
				case ($urandom_range(0, 4))
					0: w.value = SAT_MAX;
					1: w.value = SAT_MIN;
					2: w.value = '0;
					3: w.value = MINUS_LSB;
					default: w.value = Q_ONE;
				endcase
			end
		endcase
		return w;
	endfunction

	initial begin : stimulus
		load_word_t w;
		int kind;
		int n;
		int sent;
		logic sel;
		arst_n           <= 1'b0;
		loads.valid      <= 1'b0;
		loads.matrix_sel <= SEL_LEFT;
		loads.elem_index <= '0;
		loads.elem_value <= '0;
		loads.compute    <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity into A and zero into B, so that no product ever reads an unwritten entry.
		for (int i = 0; i < 2*CELLS; i++) begin
			w = '0;
			w.sel = (i >= CELLS) ? SEL_RIGHT : SEL_LEFT;
			w.index = IDX_W'(i % CELLS);
			w.value = (i < CELLS && i % (DIM+1) == 0) ? Q_ONE : '0;
			w.compute = (i == 2*CELLS-1);
			w.typed = w.compute;
			send_word(w);
		end
		foreach (directed_rows[i]) begin
			send_word(directed_rows[i]);
		end

		// Mostly short update runs ending in a product, some full reloads, some bare loads.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			kind = $urandom_range(0, 19);
			sel = 1'($urandom_range(0, 1));
			if (kind < 14) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					send_word(random_load(1'($urandom_range(0, 1)),
						IDX_W'($urandom_range(0, CELLS-1)), i == n-1));
				end
			end else if (kind < 17) begin
				n = CELLS;
				for (int i = 0; i < n; i++) begin
					send_word(random_load(sel, IDX_W'(i), i == n-1));
				end
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					send_word(random_load(1'($urandom_range(0, 1)),
						IDX_W'($urandom_range(0, CELLS-1)), 1'b0));
				end
			end
			sent += n;
		end
		loads.valid <= 1'b0;

		while (expected_products.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("matrix_multiply_4x4_tb: clean");
		end else begin
			$display("matrix_multiply_4x4_tb: errors");
		end
		$finish;
	end

	// The receiver changes its stall pattern now and then, and once holds off for a long
	// stretch so that the output backs up into the load side.
	initial begin : receiver
		int mode;
		int mode_left;
		bit hold_done;
		logic [7:0] pattern;
		products.ready <= 1'b0;
		mode = 0;
		mode_left = 0;
		hold_done = 1'b0;
		pattern = 8'b1011_0010;
		@(posedge arst_n);
		forever begin
			if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
				products.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (mode)
				0: products.ready <= 1'b1;
				1: products.ready <= 1'($urandom_range(0, 1));
				2: products.ready <= ($urandom_range(0, 3) == 0);
				default: begin
					products.ready <= pattern[0];
					pattern = {pattern[0], pattern[7:1]};
				end
			endcase
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_products
		product_word_t want;
		if (arst_n && products.valid && products.ready) begin
			results_seen <= results_seen + 1;
			if (expected_products.size() == 0) begin
				$error("unexpected product word: out_index %0d out_value %h last %b",
					products.out_index, products.out_value, products.last);
				mismatches++;
			end else begin
				want = expected_products.pop_front();
				if (products.out_index !== want.index) begin
					$error("out_index: expected %0d, got %0d", want.index, products.out_index);
					mismatches++;
				end
				if (products.out_value !== want.value) begin
					$error("out_value: expected %h, got %h", want.value, products.out_value);
					mismatches++;
				end
				if (products.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, products.last);
					mismatches++;
				end
			end
		end
	end

	// Ends the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (loads.valid && loads.ready) || (products.valid && products.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("matrix_multiply_4x4_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end
endmodule
